>>> src/i2c_master_byte_transfer_core_defines.svh
// Assertion macros shared by the I2C byte-transfer engine.
`ifndef I2C_MASTER_BYTE_TRANSFER_CORE_DEFINES_SVH
`define I2C_MASTER_BYTE_TRANSFER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CMBT_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMBT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/i2cmbt_pkg.sv
`default_nettype none

package i2cmbt_pkg;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK        = 2'd0;
  localparam logic [1:0] KIND_LOAD        = 2'd1;
  localparam logic [1:0] KIND_START_WRITE = 2'd2;
  localparam logic [1:0] KIND_START_READ  = 2'd3;

  // Status codes.
  localparam logic [1:0] STATUS_IDLE  = 2'd0;
  localparam logic [1:0] STATUS_BUSY  = 2'd1;
  localparam logic [1:0] STATUS_DONE  = 2'd2;
  localparam logic [1:0] STATUS_ABORT = 2'd3;

  // Bits per byte on the bus and the largest transfer length.
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;
  localparam logic [4:0] MAX_COUNT     = 5'd16;

  // Reset value of the quarter period register.
  localparam logic [15:0] QUARTER_RESET = 16'd250;

  typedef struct packed {
    logic [1:0] kind;
    logic       sda_in;
    logic [7:0] data_byte;
    logic [3:0] buffer_index;
    logic [6:0] target_address;
    logic [4:0] byte_count;
  } i2cmbt_in_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] read_byte;
    logic       read_valid;
    logic       read_last;
    logic [1:0] status;
  } i2cmbt_out_t;

  // Write buffer access from the sequencer; eight-bit indices cover a depth of up to 256.
  typedef struct packed {
    logic       wr_en;
    logic [7:0] wr_index;
    logic [7:0] wr_data;
    logic [7:0] rd_index;
  } i2cmbt_buf_req_t;

endpackage

`default_nettype wire

>>> src/i2cmbt_wbuf.sv
`default_nettype none

module i2cmbt_wbuf #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic                        clk,
  input  wire i2cmbt_pkg::i2cmbt_buf_req_t req,
  output logic [7:0]                       rd_data
);
  import i2cmbt_pkg::*;

  localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

  logic [7:0]    mem [BUFFER_DEPTH];
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_addr = req.wr_index[AW-1:0];
  assign rd_addr = req.rd_index[AW-1:0];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[wr_addr] <= req.wr_data;
    end
  end

  // Registered read, forwarding a write to the same slot in the same cycle.
  always_ff @(posedge clk) begin
    if (req.wr_en && (wr_addr == rd_addr)) begin
      rd_data <= req.wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> src/i2cmbt_seq.sv
`default_nettype none
`include "i2c_master_byte_transfer_core_defines.svh"

module i2cmbt_seq #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write_enable,
  input  wire logic [15:0]                  cfg_write_data,
  input  wire logic                         process,
  input  wire i2cmbt_pkg::i2cmbt_in_t       item,
  input  wire logic [7:0]                   buf_rd_data,
  output i2cmbt_pkg::i2cmbt_buf_req_t       buf_req,
  output i2cmbt_pkg::i2cmbt_out_t          result
);
  import i2cmbt_pkg::*;

  localparam logic [8:0] DEPTH_W = 9'(BUFFER_DEPTH);

  typedef enum logic [23:0] {
    PH_IDLE  = 24'h000001,
    PH_DONE  = 24'h000002,
    PH_ABORT = 24'h000004,
    PH_ST0   = 24'h000008,
    PH_ST1   = 24'h000010,
    PH_PB0   = 24'h000020,
    PH_PB1   = 24'h000040,
    PH_PB2   = 24'h000080,
    PH_PB3   = 24'h000100,
    PH_AK0   = 24'h000200,
    PH_AK1   = 24'h000400,
    PH_AK2   = 24'h000800,
    PH_AK3   = 24'h001000,
    PH_RB0   = 24'h002000,
    PH_RB1   = 24'h004000,
    PH_RB2   = 24'h008000,
    PH_RB3   = 24'h010000,
    PH_MA0   = 24'h020000,
    PH_MA1   = 24'h040000,
    PH_MA2   = 24'h080000,
    PH_MA3   = 24'h100000,
    PH_SP0   = 24'h200000,
    PH_SP1   = 24'h400000,
    PH_SP2   = 24'h800000
  } phase_t;

  // Registered state.
  logic [15:0] quarter_period_ticks;
  phase_t      phase;
  logic [15:0] quarter_counter;
  logic [3:0]  bit_counter;
  logic [4:0]  byte_counter;
  logic [7:0]  shift_register;
  logic [4:0]  transfer_length;
  logic        read_mode;
  logic        scl_rel;
  logic        sda_rel;
  logic        addr_stage;

  // Next values.
  phase_t      phase_next;
  logic [15:0] quarter_counter_next;
  logic [3:0]  bit_counter_next;
  logic [4:0]  byte_counter_next;
  logic [7:0]  shift_register_next;
  logic [4:0]  transfer_length_next;
  logic        read_mode_next;
  logic        scl_rel_next;
  logic        sda_rel_next;
  logic        addr_stage_next;

  // Working signals of the step logic.
  logic        busy;
  logic        do_enter;
  logic        do_frame;
  phase_t      target;
  phase_t      successor;
  logic [15:0] reload;
  logic [4:0]  count_sat;
  logic [4:0]  rd_full;
  logic        rd_ok;
  logic [7:0]  rd_byte;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        out_last;
  logic [1:0]  status;

  assign busy   = !((phase == PH_IDLE) || (phase == PH_DONE) || (phase == PH_ABORT));
  assign reload = (quarter_period_ticks == 16'd0) ? 16'd1 : quarter_period_ticks;

  // The buffer slot needed when the next byte frame opens after an ACK.
  assign rd_full = addr_stage ? 5'd0 : (byte_counter + 5'd1);
  assign rd_ok   = ({4'd0, rd_full} < DEPTH_W);
  assign rd_byte = rd_ok ? buf_rd_data : 8'd0;

  // Buffer access: loads write at once, the read runs every cycle.
  always_comb begin
    buf_req.wr_en    = process && (item.kind == KIND_LOAD) &&
                       ({5'd0, item.buffer_index} < DEPTH_W);
    buf_req.wr_index = {4'd0, item.buffer_index};
    buf_req.wr_data  = item.data_byte;
    buf_req.rd_index = {3'd0, rd_full};
  end

  // Plain successor of each phase that simply moves on.
  always_comb begin
    case (phase)
      PH_ST0:  successor = PH_ST1;
      PH_ST1:  successor = PH_PB0;
      PH_PB0:  successor = PH_PB1;
      PH_PB1:  successor = PH_PB2;
      PH_PB2:  successor = PH_PB3;
      PH_AK0:  successor = PH_AK1;
      PH_AK1:  successor = PH_AK2;
      PH_AK2:  successor = PH_AK3;
      PH_RB0:  successor = PH_RB1;
      PH_RB1:  successor = PH_RB2;
      PH_RB2:  successor = PH_RB3;
      PH_MA0:  successor = PH_MA1;
      PH_MA1:  successor = PH_MA2;
      PH_MA2:  successor = PH_MA3;
      PH_SP0:  successor = PH_SP1;
      PH_SP1:  successor = PH_SP2;
      default: successor = PH_IDLE;
    endcase
  end

  // Requested length, capped at 16 bytes and, for writes, at the buffer depth.
  always_comb begin
    count_sat = (item.byte_count > MAX_COUNT) ? MAX_COUNT : item.byte_count;
    if ((item.kind == KIND_START_WRITE) && ({4'd0, count_sat} > DEPTH_W)) begin
      count_sat = DEPTH_W[4:0];
    end
  end

  // One step of the sequencer for the item in the input register.
  always_comb begin
    phase_next           = phase;
    quarter_counter_next = quarter_counter;
    bit_counter_next     = bit_counter;
    byte_counter_next    = byte_counter;
    shift_register_next  = shift_register;
    transfer_length_next = transfer_length;
    read_mode_next       = read_mode;
    scl_rel_next         = scl_rel;
    sda_rel_next         = sda_rel;
    addr_stage_next      = addr_stage;
    do_enter             = 1'b0;
    do_frame             = 1'b0;
    target               = PH_IDLE;
    out_byte             = 8'd0;
    out_valid            = 1'b0;
    out_last             = 1'b0;

    // Decide which phase to enter, if any.
    case (item.kind)
      KIND_TICK: begin
        if (busy) begin
          if (quarter_counter > 16'd1) begin
            quarter_counter_next = quarter_counter - 16'd1;
          end else begin
            case (phase)
              PH_PB3: begin
                bit_counter_next = bit_counter + 4'd1;
                target   = (bit_counter_next < BITS_PER_BYTE) ? PH_PB0 : PH_AK0;
                do_enter = 1'b1;
              end
              PH_AK3: begin
                if (addr_stage) begin
                  addr_stage_next   = 1'b0;
                  byte_counter_next = 5'd0;
                end else begin
                  byte_counter_next = byte_counter + 5'd1;
                end
                do_frame = 1'b1;
              end
              PH_RB3: begin
                target   = (bit_counter < BITS_PER_BYTE) ? PH_RB0 : PH_MA0;
                do_enter = 1'b1;
              end
              PH_MA3: begin
                byte_counter_next = byte_counter + 5'd1;
                do_frame          = 1'b1;
              end
              PH_SP2: begin
                phase_next           = PH_DONE;
                quarter_counter_next = 16'd0;
                scl_rel_next         = 1'b1;
                sda_rel_next         = 1'b1;
              end
              default: begin
                target   = successor;
                do_enter = 1'b1;
              end
            endcase
          end
        end
      end
      KIND_START_WRITE, KIND_START_READ: begin
        if (!busy) begin
          read_mode_next       = (item.kind == KIND_START_READ);
          transfer_length_next = count_sat;
          shift_register_next  = {item.target_address, read_mode_next};
          bit_counter_next     = 4'd0;
          byte_counter_next    = 5'd0;
          addr_stage_next      = 1'b1;
          scl_rel_next         = 1'b1;
          sda_rel_next         = 1'b1;
          target               = PH_ST0;
          do_enter             = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Open the next byte frame, or stop when all bytes are through.
    if (do_frame) begin
      do_enter = 1'b1;
      if (byte_counter_next >= transfer_length) begin
        target = PH_SP0;
      end else if (read_mode) begin
        bit_counter_next    = 4'd0;
        shift_register_next = 8'd0;
        target              = PH_RB0;
      end else begin
        bit_counter_next    = 4'd0;
        shift_register_next = rd_byte;
        target              = PH_PB0;
      end
    end

    // Line action taken on entry to a phase.
    if (do_enter) begin
      phase_next           = target;
      quarter_counter_next = reload;
      case (target)
        PH_ST0: sda_rel_next = 1'b0;
        PH_ST1: scl_rel_next = 1'b0;
        PH_PB0: begin
          scl_rel_next        = 1'b0;
          sda_rel_next        = shift_register_next[7];
          shift_register_next = {shift_register_next[6:0], 1'b0};
        end
        PH_PB1: scl_rel_next = 1'b1;
        PH_PB3: scl_rel_next = 1'b0;
        PH_AK0: sda_rel_next = 1'b1;
        PH_AK1: scl_rel_next = 1'b1;
        PH_AK2: begin
          if (item.sda_in) begin
            phase_next   = PH_ABORT;
            scl_rel_next = 1'b1;
            sda_rel_next = 1'b1;
          end
        end
        PH_AK3: scl_rel_next = 1'b0;
        PH_RB0: sda_rel_next = 1'b1;
        PH_RB1: scl_rel_next = 1'b1;
        PH_RB2: begin
          shift_register_next = {shift_register_next[6:0], item.sda_in};
          bit_counter_next    = bit_counter_next + 4'd1;
          if (bit_counter_next >= BITS_PER_BYTE) begin
            out_byte  = shift_register_next;
            out_valid = 1'b1;
            out_last  = ((byte_counter_next + 5'd1) == transfer_length_next);
          end
        end
        PH_RB3: scl_rel_next = 1'b0;
        PH_MA0: sda_rel_next = ((byte_counter_next + 5'd1) == transfer_length_next);
        PH_MA1: scl_rel_next = 1'b1;
        PH_MA3: scl_rel_next = 1'b0;
        PH_SP0: sda_rel_next = 1'b0;
        PH_SP1: scl_rel_next = 1'b1;
        PH_SP2: sda_rel_next = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Status follows the phase after the step.
  always_comb begin
    case (phase_next)
      PH_IDLE:  status = STATUS_IDLE;
      PH_DONE:  status = STATUS_DONE;
      PH_ABORT: status = STATUS_ABORT;
      default:  status = STATUS_BUSY;
    endcase
  end

  always_comb begin
    result.scl_release = scl_rel_next;
    result.sda_release = sda_rel_next;
    result.read_byte   = out_byte;
    result.read_valid  = out_valid;
    result.read_last   = out_last;
    result.status      = status;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      quarter_period_ticks <= QUARTER_RESET;
    end else if (cfg_write_enable) begin
      quarter_period_ticks <= cfg_write_data;
    end
  end

  // Sequencer state advances only when an item is processed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      quarter_counter <= 16'd0;
      bit_counter     <= 4'd0;
      byte_counter    <= 5'd0;
      shift_register  <= 8'd0;
      transfer_length <= 5'd0;
      read_mode       <= 1'b0;
      scl_rel         <= 1'b1;
      sda_rel         <= 1'b1;
      addr_stage      <= 1'b0;
    end else if (process) begin
      phase           <= phase_next;
      quarter_counter <= quarter_counter_next;
      bit_counter     <= bit_counter_next;
      byte_counter    <= byte_counter_next;
      shift_register  <= shift_register_next;
      transfer_length <= transfer_length_next;
      read_mode       <= read_mode_next;
      scl_rel         <= scl_rel_next;
      sda_rel         <= sda_rel_next;
      addr_stage      <= addr_stage_next;
    end
  end

  // A tick inside a quarter only counts down and leaves the phase alone.
  `I2CMBT_ASSERT_NEXT(a_quarter_countdown, clk, rst, process && (item.kind == KIND_TICK) && busy && (quarter_counter > 16'd1), (quarter_counter == $past(quarter_counter) - 16'd1) && (phase == $past(phase)), "quarter countdown changed more than the counter")

  // A received byte is reported only when the SDA sample phase is entered.
  `I2CMBT_ASSERT_SAME(a_read_in_sample, clk, rst, process && result.read_valid, (phase_next == PH_RB2) && read_mode, "read byte reported outside a read sample")

  // An abort leaves both lines released.
  `I2CMBT_ASSERT_SAME(a_abort_released, clk, rst, process && (phase_next == PH_ABORT) && (phase != PH_ABORT), result.scl_release && result.sda_release, "abort left a line driven")

endmodule

`default_nettype wire

>>> src/i2c_master_byte_transfer_core.sv
// I2C master byte-transfer engine.
// Input channel in_valid/in_stall/in_data carries one item per transaction: a time
// tick with the sampled SDA level, a write-buffer load, or a write or read start.
// Output channel out_valid/out_stall/out_data returns exactly one result per item:
// the SCL and SDA release levels after the item, a received byte with its valid
// and last flags, and the status. cfg_write_enable/cfg_write_data set the number
// of ticks per quarter of the bus bit period (zero acts as one).
// Path: an item is held in the input register, then the sequencer step writes its
// result into the result register.
// Throughput: one item per cycle while out_stall is low; the sequencer step is one
// pass of logic between the input register and the result register.
// Reset (synchronous, rst high) idles the engine with both lines released and the
// quarter period at 250; the write buffer is not cleared.
// When the receiver stalls, the result register holds and the input register still
// takes one more item; after that in_stall rises until the result moves on.
module i2c_master_byte_transfer_core #(
  parameter int BUFFER_DEPTH = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write_enable,
  input  wire logic [15:0]            cfg_write_data,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire i2cmbt_pkg::i2cmbt_in_t in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output i2cmbt_pkg::i2cmbt_out_t     out_data
);
  import i2cmbt_pkg::*;

`include "i2c_master_byte_transfer_core_defines.svh"

  logic            in_q_valid;
  i2cmbt_in_t      in_q;
  logic            advance;
  i2cmbt_out_t     result;
  i2cmbt_buf_req_t buf_req;
  logic [7:0]      buf_rd_data;

  // The held item moves on when the result register is free or being emptied.
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= in_data;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  i2cmbt_seq #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .process          (advance),
    .item             (in_q),
    .buf_rd_data      (buf_rd_data),
    .buf_req          (buf_req),
    .result           (result)
  );

  i2cmbt_wbuf #(
    .BUFFER_DEPTH(BUFFER_DEPTH)
  ) u_wbuf (
    .clk     (clk),
    .req     (buf_req),
    .rd_data (buf_rd_data)
  );

  // A processed item always lands in the result register.
  `I2CMBT_ASSERT_NEXT(a_result_loaded, clk, rst, advance, out_valid, "processed item produced no result")

  // An item held back in the input register is neither lost nor altered.
  `I2CMBT_ASSERT_NEXT(a_item_held, clk, rst, in_q_valid && !advance, in_q_valid && $stable(in_q), "held input item was lost")

  // A loaded result that is not taken is not overwritten.
  `I2CMBT_ASSERT_SAME(a_no_overwrite, clk, rst, out_valid && out_stall, !advance, "result overwritten while stalled")

endmodule

`default_nettype wire
